>>> src/buddy_block_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the buddy block allocator checker
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba checker: same-cycle rule violated");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba checker: next-cycle rule violated");

`endif

>>> src/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes, types and helpers of the buddy block allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // sizing
    localparam int MAX_ORDER_LIMIT     = 10;
    localparam int MAX_MIN_BLOCK_SHIFT = 12;
    localparam int NUM_BLK             = 1 << MAX_ORDER_LIMIT;
    localparam int NUM_ENT             = 2 * NUM_BLK - 1;
    localparam int NUM_ORD             = MAX_ORDER_LIMIT + 1;
    localparam int IDX_W               = MAX_ORDER_LIMIT;
    localparam int ADDR_W              = MAX_ORDER_LIMIT + 1;
    localparam int CNT_W               = MAX_ORDER_LIMIT + 1;
    localparam int ORD_W               = 4;
    localparam int SIZE_W              = 23;
    localparam int OFFS_W              = 22;
    localparam int STAT_W              = 3;
    localparam int CLOG_W              = 5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BIG    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOFREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADOFF = 3'd4;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // register index (paddr bit 2)
    localparam logic REG_SHIFT = 1'b0;
    localparam logic REG_MAXO  = 1'b1;

    // datapath operations
    localparam logic [4:0] OP_NONE        = 5'd0;
    localparam logic [4:0] OP_CLEAR       = 5'd1;
    localparam logic [4:0] OP_LATCH       = 5'd2;
    localparam logic [4:0] OP_START_ALLOC = 5'd3;
    localparam logic [4:0] OP_NEXT_ORD    = 5'd4;
    localparam logic [4:0] OP_SPLIT_RD    = 5'd5;
    localparam logic [4:0] OP_SPLIT_WR    = 5'd6;
    localparam logic [4:0] OP_PUSH        = 5'd7;
    localparam logic [4:0] OP_POP_RD      = 5'd8;
    localparam logic [4:0] OP_ALLOC_DONE  = 5'd9;
    localparam logic [4:0] OP_FREE_RD     = 5'd10;
    localparam logic [4:0] OP_FREE_CHK    = 5'd11;
    localparam logic [4:0] OP_SCAN_INIT   = 5'd12;
    localparam logic [4:0] OP_SCAN_RD     = 5'd13;
    localparam logic [4:0] OP_SHIFT_RD    = 5'd14;
    localparam logic [4:0] OP_SHIFT_WR    = 5'd15;
    localparam logic [4:0] OP_MERGE       = 5'd16;
    localparam logic [4:0] OP_PUSH_DONE   = 5'd17;
    localparam logic [4:0] OP_ERR         = 5'd18;
    localparam logic [4:0] OP_OUT         = 5'd19;

    // controller to datapath
    typedef struct packed {
        logic [4:0]        op;
        logic [STAT_W-1:0] code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cfg_wr;
        logic clr_done;
        logic req_free;
        logic size_zero;
        logic too_large;
        logic off_bad;
        logic rec_zero;
        logic cnt_zero;
        logic ord_gt_want;
        logic ord_gt_max;
        logic ord_lt_max;
        logic pos_zero;
        logic match;
        logic shift_more;
        logic out_busy;
    } sts_t;

    // first slot of an order's list in the entry memory
    function automatic logic [ADDR_W-1:0] slot_base(input logic [ORD_W-1:0] k);
        logic [ADDR_W:0] full;
        full = (ADDR_W+1)'(1 << ADDR_W);
        full = full - (full >> k);
        return full[ADDR_W-1:0];
    endfunction

    // slot count of an order's list
    function automatic logic [CNT_W-1:0] slot_cap(input logic [ORD_W-1:0] k);
        logic [CNT_W-1:0] c;
        c = CNT_W'(NUM_BLK);
        return c >> k;
    endfunction

endpackage

`default_nettype wire

>>> src/bba_datapath.sv
// ---------------------------------------------------------------------------
// bba_datapath
// Register file, free-list and allocation-record memories, list counts,
// config registers and output register of the buddy allocator.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bba_pkg::cmd_t                    cmd,
    output bba_pkg::sts_t                    sts,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    // request fields
    input  logic                             req_type,
    input  logic [bba_pkg::SIZE_W-1:0]       request_size,
    input  logic [bba_pkg::OFFS_W-1:0]       free_offset,
    // result channel
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [bba_pkg::STAT_W-1:0]       status,
    output logic [bba_pkg::OFFS_W-1:0]       block_offset,
    output logic [bba_pkg::ORD_W-1:0]        block_order
);

    // memories
    logic [bba_pkg::IDX_W-1:0] ent_mem [bba_pkg::NUM_ENT];
    logic [bba_pkg::ORD_W-1:0] rec_mem [bba_pkg::NUM_BLK];

    // config
    logic [3:0] shift_reg, shift_next;
    logic [3:0] maxo_reg, maxo_next;
    logic       cfg_wr;
    logic [3:0] cfg_val;

    // request and working registers
    logic                         req_reg;
    logic [bba_pkg::SIZE_W-1:0]   size_reg;
    logic [bba_pkg::OFFS_W-1:0]   offs_reg;
    logic [bba_pkg::ORD_W-1:0]    ord_reg, want_reg;
    logic [bba_pkg::IDX_W-1:0]    idx_reg, buddy_reg;
    logic [bba_pkg::CNT_W-1:0]    pos_reg;
    logic [bba_pkg::IDX_W-1:0]    clr_reg;
    logic [bba_pkg::CNT_W-1:0]    cnt_reg [bba_pkg::NUM_ORD];
    logic [bba_pkg::IDX_W-1:0]    rd_reg;
    logic [bba_pkg::ORD_W-1:0]    rec_rd_reg;
    logic [bba_pkg::STAT_W-1:0]   res_status_reg;
    logic [bba_pkg::IDX_W-1:0]    res_idx_reg;
    logic [bba_pkg::ORD_W-1:0]    res_ord_reg;
    logic                         out_valid_reg;
    logic [bba_pkg::STAT_W-1:0]   out_status_reg;
    logic [bba_pkg::OFFS_W-1:0]   out_offset_reg;
    logic [bba_pkg::ORD_W-1:0]    out_order_reg;

    // derived values
    logic [bba_pkg::CNT_W-1:0]    cnt_cur;
    logic [bba_pkg::ADDR_W-1:0]   base_cur;
    logic                         cnt_full;
    logic [bba_pkg::SIZE_W-1:0]   size_m1;
    logic [bba_pkg::CLOG_W-1:0]   clog;
    logic [bba_pkg::CLOG_W-1:0]   want_full;
    logic [bba_pkg::OFFS_W-1:0]   bi;
    logic [bba_pkg::OFFS_W-1:0]   off_mask;
    logic [bba_pkg::IDX_W-1:0]    ord_bit;
    logic [bba_pkg::OFFS_W-1:0]   res_offset;

    // memory port controls
    logic                         ent_we;
    logic [bba_pkg::ADDR_W-1:0]   ent_waddr, ent_raddr;
    logic [bba_pkg::IDX_W-1:0]    ent_wdata;
    logic                         ent_re;
    logic                         rec_we, rec_re;
    logic [bba_pkg::IDX_W-1:0]    rec_waddr, rec_raddr;
    logic [bba_pkg::ORD_W-1:0]    rec_wdata;

    // config decode
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_val = pwdata[3:0];
    assign prdata  = (paddr[2] == bba_pkg::REG_MAXO) ? {28'd0, maxo_reg} : {28'd0, shift_reg};

    always_comb
    begin
        shift_next = shift_reg;
        maxo_next  = maxo_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == bba_pkg::REG_SHIFT)
                shift_next = (cfg_val > 4'(bba_pkg::MAX_MIN_BLOCK_SHIFT)) ?
                             4'(bba_pkg::MAX_MIN_BLOCK_SHIFT) : cfg_val;
            else
                maxo_next = (cfg_val > 4'(bba_pkg::MAX_ORDER_LIMIT)) ?
                            4'(bba_pkg::MAX_ORDER_LIMIT) : cfg_val;
        end
    end

    // current list view
    assign cnt_cur  = (ord_reg <= 4'(bba_pkg::MAX_ORDER_LIMIT)) ? cnt_reg[ord_reg] : '0;
    assign base_cur = bba_pkg::slot_base(ord_reg);
    assign cnt_full = cnt_cur >= bba_pkg::slot_cap(ord_reg);
    assign ord_bit  = bba_pkg::IDX_W'(1) << ord_reg;

    // order for a size: bit length of size-1, less the block shift
    assign size_m1 = size_reg - bba_pkg::SIZE_W'(1);
    always_comb
    begin
        clog = '0;
        for (int i = 0; i < bba_pkg::SIZE_W; i++)
            if (size_m1[i])
                clog = bba_pkg::CLOG_W'(i + 1);
    end
    assign want_full = (clog > {1'b0, shift_reg}) ? clog - {1'b0, shift_reg} : '0;

    // free offset checks
    assign bi       = offs_reg >> shift_reg;
    assign off_mask = ~({bba_pkg::OFFS_W{1'b1}} << shift_reg);

    // status to controller
    always_comb
    begin
        sts.cfg_wr      = cfg_wr;
        sts.clr_done    = &clr_reg;
        sts.req_free    = (req_reg == bba_pkg::REQ_FREE);
        sts.size_zero   = (size_reg == '0);
        sts.too_large   = want_full > {1'b0, maxo_reg};
        sts.off_bad     = ((offs_reg & off_mask) != '0) || ((bi >> maxo_reg) != '0);
        sts.rec_zero    = (rec_rd_reg == '0);
        sts.cnt_zero    = (cnt_cur == '0);
        sts.ord_gt_want = ord_reg > want_reg;
        sts.ord_gt_max  = ord_reg > maxo_reg;
        sts.ord_lt_max  = ord_reg < maxo_reg;
        sts.pos_zero    = (pos_reg == '0);
        sts.match       = (rd_reg == buddy_reg);
        sts.shift_more  = ({1'b0, pos_reg} + (bba_pkg::CNT_W+1)'(1)) < {1'b0, cnt_cur};
        sts.out_busy    = out_valid_reg & ~out_ready;
    end

    // memory port selection
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = base_cur + cnt_cur;
        ent_wdata = idx_reg;
        ent_re    = 1'b0;
        ent_raddr = base_cur + cnt_cur - bba_pkg::ADDR_W'(1);
        rec_we    = 1'b0;
        rec_waddr = idx_reg;
        rec_wdata = '0;
        rec_re    = 1'b0;
        rec_raddr = bi[bba_pkg::IDX_W-1:0];
        case (cmd.op)
            bba_pkg::OP_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = bba_pkg::slot_base(maxo_reg);
                ent_wdata = '0;
                rec_we    = 1'b1;
                rec_waddr = clr_reg;
            end
            bba_pkg::OP_SPLIT_RD, bba_pkg::OP_POP_RD:
                ent_re = 1'b1;
            bba_pkg::OP_SPLIT_WR:
            begin
                ent_we    = ~cnt_full;
                ent_wdata = rd_reg + ord_bit;
            end
            bba_pkg::OP_PUSH, bba_pkg::OP_PUSH_DONE:
                ent_we = ~cnt_full;
            bba_pkg::OP_ALLOC_DONE:
            begin
                rec_we    = 1'b1;
                rec_waddr = rd_reg;
                rec_wdata = ord_reg + bba_pkg::ORD_W'(1);
            end
            bba_pkg::OP_FREE_RD:
                rec_re = 1'b1;
            bba_pkg::OP_FREE_CHK:
                rec_we = 1'b1;
            bba_pkg::OP_SCAN_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = base_cur + pos_reg - bba_pkg::ADDR_W'(1);
            end
            bba_pkg::OP_SHIFT_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = base_cur + pos_reg + bba_pkg::ADDR_W'(1);
            end
            bba_pkg::OP_SHIFT_WR:
            begin
                ent_we    = 1'b1;
                ent_waddr = base_cur + pos_reg;
                ent_wdata = rd_reg;
            end
            default: ;
        endcase
    end

    // free-list entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (ent_re)
            rd_reg <= ent_mem[ent_raddr];
    end

    // allocation record memory
    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[rec_waddr] <= rec_wdata;
        if (rec_re)
            rec_rd_reg <= rec_mem[rec_raddr];
    end

    // config, counts, clear counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= 4'd4;
            maxo_reg      <= 4'(bba_pkg::MAX_ORDER_LIMIT);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < bba_pkg::NUM_ORD; k++)
                cnt_reg[k] <= (k == bba_pkg::MAX_ORDER_LIMIT) ? bba_pkg::CNT_W'(1) : '0;
        end
        else
        begin
            shift_reg <= shift_next;
            maxo_reg  <= maxo_next;
            if (cfg_wr)
            begin
                clr_reg <= '0;
                for (int k = 0; k < bba_pkg::NUM_ORD; k++)
                    cnt_reg[k] <= (4'(k) == maxo_next) ? bba_pkg::CNT_W'(1) : '0;
            end
            else
            begin
                case (cmd.op)
                    bba_pkg::OP_CLEAR:
                        clr_reg <= clr_reg + bba_pkg::IDX_W'(1);
                    bba_pkg::OP_SPLIT_RD, bba_pkg::OP_POP_RD, bba_pkg::OP_MERGE:
                        cnt_reg[ord_reg] <= cnt_cur - bba_pkg::CNT_W'(1);
                    bba_pkg::OP_SPLIT_WR, bba_pkg::OP_PUSH, bba_pkg::OP_PUSH_DONE:
                        if (!cnt_full)
                            cnt_reg[ord_reg] <= cnt_cur + bba_pkg::CNT_W'(1);
                    default: ;
                endcase
            end
            if (cmd.op == bba_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bba_pkg::OP_LATCH:
            begin
                req_reg  <= req_type;
                size_reg <= request_size;
                offs_reg <= free_offset;
            end
            bba_pkg::OP_START_ALLOC:
            begin
                ord_reg  <= want_full[bba_pkg::ORD_W-1:0];
                want_reg <= want_full[bba_pkg::ORD_W-1:0];
            end
            bba_pkg::OP_NEXT_ORD:
                ord_reg <= ord_reg + bba_pkg::ORD_W'(1);
            bba_pkg::OP_SPLIT_RD:
                ord_reg <= ord_reg - bba_pkg::ORD_W'(1);
            bba_pkg::OP_SPLIT_WR:
                idx_reg <= rd_reg;
            bba_pkg::OP_ALLOC_DONE:
            begin
                res_status_reg <= bba_pkg::ST_OK;
                res_idx_reg    <= rd_reg;
                res_ord_reg    <= ord_reg;
            end
            bba_pkg::OP_FREE_RD:
                idx_reg <= bi[bba_pkg::IDX_W-1:0];
            bba_pkg::OP_FREE_CHK:
                ord_reg <= rec_rd_reg - bba_pkg::ORD_W'(1);
            bba_pkg::OP_SCAN_INIT:
            begin
                pos_reg   <= cnt_cur;
                buddy_reg <= idx_reg ^ ord_bit;
            end
            bba_pkg::OP_SCAN_RD:
                pos_reg <= pos_reg - bba_pkg::CNT_W'(1);
            bba_pkg::OP_SHIFT_WR:
                pos_reg <= pos_reg + bba_pkg::CNT_W'(1);
            bba_pkg::OP_MERGE:
            begin
                if (buddy_reg < idx_reg)
                    idx_reg <= buddy_reg;
                ord_reg <= ord_reg + bba_pkg::ORD_W'(1);
            end
            bba_pkg::OP_PUSH_DONE:
            begin
                res_status_reg <= bba_pkg::ST_OK;
                res_idx_reg    <= idx_reg;
                res_ord_reg    <= ord_reg;
            end
            bba_pkg::OP_ERR:
            begin
                res_status_reg <= cmd.code;
                res_idx_reg    <= '0;
                res_ord_reg    <= '0;
            end
            default: ;
        endcase
    end

    // output word
    assign res_offset = (res_status_reg == bba_pkg::ST_OK) ?
                        (bba_pkg::OFFS_W'(res_idx_reg) << shift_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.op == bba_pkg::OP_OUT)
        begin
            out_status_reg <= res_status_reg;
            out_offset_reg <= res_offset;
            out_order_reg  <= (res_status_reg == bba_pkg::ST_OK) ? res_ord_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign block_offset = out_offset_reg;
    assign block_order  = out_order_reg;

endmodule

`default_nettype wire

>>> src/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the buddy allocator: clear pass, order search, splits,
// buddy scan and merge, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECODE    = 4'd2;
    localparam logic [3:0] S_SEARCH    = 4'd3;
    localparam logic [3:0] S_SPLIT_WR  = 4'd4;
    localparam logic [3:0] S_SPLIT_PSH = 4'd5;
    localparam logic [3:0] S_POP_WR    = 4'd6;
    localparam logic [3:0] S_FREE_CHK  = 4'd7;
    localparam logic [3:0] S_MERGE     = 4'd8;
    localparam logic [3:0] S_SCAN      = 4'd9;
    localparam logic [3:0] S_CMP       = 4'd10;
    localparam logic [3:0] S_SHIFT     = 4'd11;
    localparam logic [3:0] S_SHIFT_WR  = 4'd12;
    localparam logic [3:0] S_PUSH      = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bba_pkg::OP_NONE;
        cmd.code   = bba_pkg::ST_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bba_pkg::OP_CLEAR;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = bba_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            S_DECODE:
                if (sts.req_free)
                begin
                    if (sts.off_bad)
                    begin
                        cmd.op     = bba_pkg::OP_ERR;
                        cmd.code   = bba_pkg::ST_BADOFF;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = bba_pkg::OP_FREE_RD;
                        state_next = S_FREE_CHK;
                    end
                end
                else if (sts.size_zero)
                begin
                    cmd.op     = bba_pkg::OP_ERR;
                    cmd.code   = bba_pkg::ST_ZERO;
                    state_next = S_DONE;
                end
                else if (sts.too_large)
                begin
                    cmd.op     = bba_pkg::OP_ERR;
                    cmd.code   = bba_pkg::ST_BIG;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_START_ALLOC;
                    state_next = S_SEARCH;
                end
            S_SEARCH:
                if (sts.ord_gt_max)
                begin
                    cmd.op     = bba_pkg::OP_ERR;
                    cmd.code   = bba_pkg::ST_NOFREE;
                    state_next = S_DONE;
                end
                else if (sts.cnt_zero)
                    cmd.op = bba_pkg::OP_NEXT_ORD;
                else if (sts.ord_gt_want)
                begin
                    cmd.op     = bba_pkg::OP_SPLIT_RD;
                    state_next = S_SPLIT_WR;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_POP_RD;
                    state_next = S_POP_WR;
                end
            S_SPLIT_WR:
            begin
                cmd.op     = bba_pkg::OP_SPLIT_WR;
                state_next = S_SPLIT_PSH;
            end
            S_SPLIT_PSH:
            begin
                cmd.op     = bba_pkg::OP_PUSH;
                state_next = S_SEARCH;
            end
            S_POP_WR:
            begin
                cmd.op     = bba_pkg::OP_ALLOC_DONE;
                state_next = S_DONE;
            end
            S_FREE_CHK:
                if (sts.rec_zero)
                begin
                    cmd.op     = bba_pkg::OP_ERR;
                    cmd.code   = bba_pkg::ST_BADOFF;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_FREE_CHK;
                    state_next = S_MERGE;
                end
            S_MERGE:
                if (sts.ord_lt_max)
                begin
                    cmd.op     = bba_pkg::OP_SCAN_INIT;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_PUSH;
            S_SCAN:
                if (sts.pos_zero)
                    state_next = S_PUSH;
                else
                begin
                    cmd.op     = bba_pkg::OP_SCAN_RD;
                    state_next = S_CMP;
                end
            S_CMP:
                state_next = sts.match ? S_SHIFT : S_SCAN;
            S_SHIFT:
                if (sts.shift_more)
                begin
                    cmd.op     = bba_pkg::OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.op     = bba_pkg::OP_MERGE;
                    state_next = S_MERGE;
                end
            S_SHIFT_WR:
            begin
                cmd.op     = bba_pkg::OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_PUSH:
            begin
                cmd.op     = bba_pkg::OP_PUSH_DONE;
                state_next = S_DONE;
            end
            S_DONE:
                if (!sts.out_busy)
                begin
                    cmd.op     = bba_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_CLEAR;
        endcase
        // a config write restarts the clear pass
        if (sts.cfg_wr)
        begin
            cmd.op     = bba_pkg::OP_NONE;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> src/buddy_block_allocator.sv
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator top level: sequencer plus datapath, APB config port.
// ---------------------------------------------------------------------------
// Request steps: an allocate searches upward past empty orders, then splits a larger block
//   once per order down to the wanted order; a free reads the allocation record, then per
//   order scans the list for the buddy and moves the later entries down over it to merge;
//   errors and no free block end early; a stalled result adds its stall.
// One word in work at a time: the next word is taken the cycle after the result is loaded.
// Reset and every config write start a clear of all 1024 entries of the allocation record.

`default_nettype none

module buddy_block_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [bba_pkg::SIZE_W-1:0]     request_size,
    input  logic [bba_pkg::OFFS_W-1:0]     free_offset,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bba_pkg::STAT_W-1:0]     status,
    output logic [bba_pkg::OFFS_W-1:0]     block_offset,
    output logic [bba_pkg::ORD_W-1:0]      block_order
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;

    assign pready = 1'b1;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .req_type     (req_type),
        .request_size (request_size),
        .free_offset  (free_offset),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .block_offset (block_offset),
        .block_order  (block_order)
    );

endmodule

`default_nettype wire

>>> src/bba_checker.sv
// ---------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "buddy_block_allocator_macros.svh"

module bba_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pready,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bba_pkg::STAT_W-1:0]  status,
    input logic [bba_pkg::OFFS_W-1:0]  block_offset,
    input logic [bba_pkg::ORD_W-1:0]   block_order
);

    // failed requests carry no block
    `BBA_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (status != bba_pkg::ST_OK), (block_offset == '0) && (block_order == '0))

    // one request in work: ready drops after an accept
    `BBA_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)

    // returned order never exceeds the region
    `BBA_ASSERT_NOW(a_order_range, clk, rst_n, out_valid, block_order <= 4'(bba_pkg::MAX_ORDER_LIMIT))

    // stalled result word holds
    `BBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(block_offset))

    // config port never waits
    `BBA_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .block_offset (block_offset),
    .block_order  (block_order)
);

`default_nettype wire
